// ===== rtl/reciprocal_frequency_meter_core_assert.svh =====
// Assertion macros for the reciprocal frequency meter.
// Used by the top level; needs clk_i and rst_ni in scope.
`ifndef RECIPROCAL_FREQUENCY_METER_CORE_ASSERT_SVH
`define RECIPROCAL_FREQUENCY_METER_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define RFM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked in the cycle after the antecedent
`define RFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rfm_pkg.sv =====
// Shared types and constants for the reciprocal frequency meter.
// No dependencies.
package rfm_pkg;

  localparam int unsigned TIMESTAMP_WIDTH = 32;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned DIV_STEPS       = DATA_W;
  localparam int unsigned DIV_CNT_W       = $clog2(DIV_STEPS);

  localparam logic [DATA_W-1:0] REF_RATE_RESET  = DATA_W'(36000000);
  localparam logic [DATA_W-1:0] FAST_THR_RESET  = DATA_W'(360);

  typedef enum logic {
    REG_REFERENCE_RATE = 1'b0,
    REG_FAST_THRESHOLD = 1'b1
  } cfg_reg_e;

  // controller to datapath
  typedef struct packed {
    logic accept; // a sample is taken this cycle
    logic load;   // rising edge taken: capture and start the divide
    logic step;   // one restoring divide step
  } rfm_cmd_t;

endpackage

// ===== rtl/rfm_ctrl.sv =====
// Controller for the reciprocal frequency meter: idle / divide / output FSM.
// Depends on rfm_pkg.
module rfm_ctrl import rfm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     rise_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rfm_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy;

  assign busy        = (state_q != ST_IDLE);
  assign in_stall_o  = rise_i & busy;
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    cmd_o.accept = in_valid_i & ~in_stall_o;
    cmd_o.load   = in_valid_i & rise_i & ~busy;
    cmd_o.step   = (state_q == ST_DIV);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (cmd_o.load) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/rfm_dp.sv =====
// Datapath for the reciprocal frequency meter: timestamp counter, capture,
// configuration registers and a radix-2 restoring divider. Depends on rfm_pkg.
module rfm_dp import rfm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              level_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [DATA_W-1:0] cfg_wdata_i,
  input  rfm_cmd_t          cmd_i,
  output logic              rise_o,
  output logic [DATA_W-1:0] period_o,
  output logic [DATA_W-1:0] frequency_o,
  output logic              too_fast_o
);

  logic                       prev_q;
  logic [TIMESTAMP_WIDTH-1:0] tick_q, last_q;
  logic [DATA_W-1:0]          rate_q, thr_q;
  logic [DATA_W-1:0]          period_q, rem_q, quo_q;
  logic                       too_fast_q;

  logic [TIMESTAMP_WIDTH-1:0] diff;
  logic [DATA_W-1:0]          period_d;
  logic [DATA_W:0]            shifted;
  logic [DATA_W+1:0]          trial;

  assign rise_o   = level_i & ~prev_q;
  assign diff     = tick_q - last_q;
  assign period_d = DATA_W'(diff);
  assign shifted  = {rem_q, quo_q[DATA_W-1]};
  assign trial    = {1'b0, shifted} - {2'b00, period_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b0;
      tick_q <= '0;
      last_q <= '0;
      rate_q <= REF_RATE_RESET;
      thr_q  <= FAST_THR_RESET;
    end else begin
      if (cmd_i.accept) begin
        prev_q <= level_i;
        tick_q <= tick_q + TIMESTAMP_WIDTH'(1);
      end
      if (cmd_i.load) begin
        last_q <= tick_q;
      end
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_REFERENCE_RATE: rate_q <= cfg_wdata_i;
          REG_FAST_THRESHOLD: thr_q  <= cfg_wdata_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      period_q   <= period_d;
      too_fast_q <= (period_d < thr_q);
      rem_q      <= '0;
      quo_q      <= rate_q;
    end else if (cmd_i.step) begin
      if (!trial[DATA_W+1]) begin
        rem_q <= trial[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign period_o    = period_q;
  assign frequency_o = (period_q == '0) ? '0 : quo_q;
  assign too_fast_o  = too_fast_q;

endmodule

// ===== rtl/reciprocal_frequency_meter_core.sv =====
// Reciprocal frequency meter top level: controller plus datapath.
// Samples are taken one per cycle; a rising edge starts a 32-step divide
// and its result is valid once the divide is done, then waits.
// A further rising edge is stalled until that result is taken (the divider
// produces one quotient bit per cycle); other samples flow freely.
// Reset (rst_ni low, asynchronous) clears the counter, capture and FSM.
module reciprocal_frequency_meter_core import rfm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              level_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] period_o,
  output logic [DATA_W-1:0] frequency_o,
  output logic              too_fast_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [DATA_W-1:0] cfg_wdata_i
);

  rfm_cmd_t cmd;
  logic     rise;

  rfm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .rise_i      (rise),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  rfm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .level_i     (level_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .rise_o      (rise),
    .period_o    (period_o),
    .frequency_o (frequency_o),
    .too_fast_o  (too_fast_o)
  );

`include "reciprocal_frequency_meter_core_assert.svh"

  `RFM_ASSERT_NEXT(a_no_early_result, cmd.load, !out_valid_o, "result shown before divide")
  `RFM_ASSERT_IMP(a_edge_held_busy, out_valid_o && rise, in_stall_o, "edge taken while busy")
  `RFM_ASSERT_IMP(a_zero_period, out_valid_o && (period_o == '0), frequency_o == '0,
                  "nonzero frequency for zero period")

endmodule

// ===== tb/sv/reciprocal_frequency_meter_core_tb.sv =====
// Self-checking testbench for reciprocal_frequency_meter_core: directed table, then random
// pulse trains under several register settings; readings are checked against the table's
// expected values or a local model. Depends on rfm_pkg and the core RTL only.
module reciprocal_frequency_meter_core_tb;
  import rfm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_W-1:0] period;
    logic [DATA_W-1:0] freq;
    logic              fast;
  } reading_t;

  // directed plan row: either a register setting or one level item
  typedef struct packed {
    logic              is_cfg;
    logic              lvl;
    logic              typed;
    logic [DATA_W-1:0] rate;
    logic [DATA_W-1:0] thr;
    reading_t          want;
  } plan_row_t;

  localparam int unsigned PLAN_LEN    = 19;
  localparam int unsigned PHASE_ITEMS = 130;
  localparam int unsigned SETTLE_CYC  = 40;
  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{1'b0, 1'b1, 1'b1, 32'd0, 32'd0, '{32'd0, 32'd0, 1'b1}},           // edge at tick 0
    '{1'b0, 1'b1, 1'b0, 32'd0, 32'd0, '{32'd0, 32'd0, 1'b0}},           // held high
    '{1'b0, 1'b0, 1'b0, 32'd0, 32'd0, '{32'd0, 32'd0, 1'b0}},
    '{1'b0, 1'b1, 1'b1, 32'd0, 32'd0, '{32'd3, 32'd12000000, 1'b1}},
    '{1'b0, 1'b0, 1'b0, 32'd0, 32'd0, '{32'd0, 32'd0, 1'b0}},
    '{1'b0, 1'b0, 1'b0, 32'd0, 32'd0, '{32'd0, 32'd0, 1'b0}},
    '{1'b1, 1'b0, 1'b0, 32'd1, 32'd0, '{32'd0, 32'd0, 1'b0}},
    '{1'b0, 1'b1, 1'b1, 32'd0, 32'd0, '{32'd3, 32'd0, 1'b0}},
    '{1'b0, 1'b0, 1'b0, 32'd0, 32'd0, '{32'd0, 32'd0, 1'b0}},
    '{1'b1, 1'b0, 1'b0, ALL_ONES, ALL_ONES, '{32'd0, 32'd0, 1'b0}},
    '{1'b0, 1'b1, 1'b1, 32'd0, 32'd0, '{32'd2, 32'h7FFF_FFFF, 1'b1}},
    '{1'b0, 1'b0, 1'b0, 32'd0, 32'd0, '{32'd0, 32'd0, 1'b0}},
    '{1'b0, 1'b1, 1'b1, 32'd0, 32'd0, '{32'd2, 32'h7FFF_FFFF, 1'b1}},
    '{1'b0, 1'b0, 1'b0, 32'd0, 32'd0, '{32'd0, 32'd0, 1'b0}},
    '{1'b0, 1'b0, 1'b0, 32'd0, 32'd0, '{32'd0, 32'd0, 1'b0}},
    '{1'b1, 1'b0, 1'b0, ALL_ONES, 32'd3, '{32'd0, 32'd0, 1'b0}},
    '{1'b0, 1'b1, 1'b1, 32'd0, 32'd0, '{32'd3, 32'h5555_5555, 1'b0}},
    '{1'b0, 1'b0, 1'b0, 32'd0, 32'd0, '{32'd0, 32'd0, 1'b0}},
    '{1'b0, 1'b1, 1'b1, 32'd0, 32'd0, '{32'd2, 32'h7FFF_FFFF, 1'b1}}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall;
  logic              level;
  logic              out_valid;
  logic              out_stall;
  logic [DATA_W-1:0] period;
  logic [DATA_W-1:0] frequency;
  logic              too_fast;
  logic              cfg_we;
  logic              cfg_idx;
  logic [DATA_W-1:0] cfg_wdata;

  // local copy of the meter
  logic [TIMESTAMP_WIDTH-1:0] tick_now;
  logic [TIMESTAMP_WIDTH-1:0] last_stamp;
  logic                       prev_level;
  logic [DATA_W-1:0]          rate_setting;
  logic [DATA_W-1:0]          thr_setting;

  reading_t pending_readings[$];
  int unsigned errors;
  int unsigned levels_fed;
  int unsigned readings_seen;
  int unsigned settings_made;
  bit calm;

  reciprocal_frequency_meter_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .level_i     (level),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .period_o    (period),
    .frequency_o (frequency),
    .too_fast_o  (too_fast),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  task automatic meter_step(input logic lvl, output bit rising, output reading_t r);
    logic [DATA_W-1:0] p;
    rising = (lvl == 1'b1) && (prev_level == 1'b0);
    r = '0;
    if (rising) begin
      p = DATA_W'(tick_now - last_stamp);
      r.period = p;
      r.freq = (p == '0) ? '0 : rate_setting / p;
      r.fast = (p < thr_setting);
      last_stamp = tick_now;
    end
    prev_level = lvl;
    tick_now = tick_now + TIMESTAMP_WIDTH'(1);
  endtask

  // offer one level item, wait for acceptance, then record what it should produce
  task automatic feed_level(input logic lvl, input bit typed, input reading_t typed_want);
    bit taken;
    bit rising;
    reading_t r;
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    level <= lvl;
    do begin
      @(negedge clk_i);
      taken = !in_stall;
      @(posedge clk_i);
    end while (!taken);
    levels_fed++;
    meter_step(lvl, rising, r);
    if (rising) pending_readings.push_back(typed ? typed_want : r);
  endtask

  task automatic apply_settings(input logic [DATA_W-1:0] rate, input logic [DATA_W-1:0] thr);
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_readings.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= REG_REFERENCE_RATE;
    cfg_wdata <= rate;
    @(posedge clk_i);
    cfg_idx <= REG_FAST_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    rate_setting = rate;
    thr_setting = thr;
    settings_made++;
  endtask

  function automatic logic [DATA_W-1:0] any_rate();
    logic [DATA_W-1:0] r;
    r = $urandom;
    return (r == '0) ? DATA_W'(1) : r;
  endfunction

  function automatic int unsigned run_length();
    return ($urandom_range(9) == 0) ? $urandom_range(7, 120) : $urandom_range(1, 6);
  endfunction

  always @(posedge clk_i) out_stall <= !calm && ($urandom_range(99) < 30);

  always @(negedge clk_i) begin : take_reading
    reading_t want;
    if (rst_ni && out_valid && !out_stall) begin
      readings_seen++;
      if (pending_readings.size() == 0) begin
        flag_mismatch($sformatf("reading with none pending, period %0d", period));
      end else begin
        want = pending_readings.pop_front();
        if (period !== want.period)
          flag_mismatch($sformatf("period %0d, want %0d", period, want.period));
        if (frequency !== want.freq)
          flag_mismatch($sformatf("frequency %0d, want %0d", frequency, want.freq));
        if (too_fast !== want.fast)
          flag_mismatch($sformatf("too_fast %0b, want %0b", too_fast, want.fast));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_start;
    int unsigned n;
    int unsigned drain;
    logic [DATA_W-1:0] rate;
    logic [DATA_W-1:0] thr;

    rst_ni = 1'b0;
    in_valid = 1'b0;
    level = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_REFERENCE_RATE;
    cfg_wdata = '0;
    calm = 1'b0;
    errors = 0;
    levels_fed = 0;
    readings_seen = 0;
    settings_made = 0;
    tick_now = '0;
    last_stamp = '0;
    prev_level = 1'b0;
    rate_setting = REF_RATE_RESET;
    thr_setting = FAST_THR_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].is_cfg) apply_settings(PLAN[i].rate, PLAN[i].thr);
      else feed_level(PLAN[i].lvl, PLAN[i].typed, PLAN[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin rate = any_rate(); thr = $urandom_range(0, 40); end
        1: begin rate = DATA_W'(1); thr = '0; end
        2: begin rate = ALL_ONES; thr = ALL_ONES; end
        3: begin rate = any_rate(); thr = $urandom_range(0, 200); end
        4: begin rate = REF_RATE_RESET; thr = FAST_THR_RESET; end
        default: begin rate = any_rate(); thr = $urandom; end
      endcase
      apply_settings(rate, thr);
      calm = (ph == 3);
      phase_start = levels_fed;
      while (levels_fed - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 85) begin
          n = run_length();
          repeat (n) feed_level(1'b0, 1'b0, '0);
          n = run_length();
          repeat (n) feed_level(1'b1, 1'b0, '0);
        end else begin
          n = $urandom_range(1, 5);
          repeat (n) feed_level(1'($urandom_range(1)), 1'b0, '0);
        end
      end
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    drain = 0;
    while (pending_readings.size() != 0 && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (pending_readings.size() != 0)
      flag_mismatch($sformatf("%0d readings never arrived", pending_readings.size()));

    $display("fed %0d level items under %0d register settings", levels_fed, settings_made);
    $display("checked %0d readings, %0d mismatches", readings_seen, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
